@@ rtl/tbt_pkg.sv @@
// Shared types, constants and helpers for the tile blit transpose writer.
package tbt_pkg;

	localparam int MAX_LINES_PER_ROW = 8;
	localparam int TILE_SIZE         = 8;
	localparam int ROW_SHIFT         = 3;
	localparam int LINES_W           = $clog2(MAX_LINES_PER_ROW + 1);
	localparam int ROW_W             = $clog2(TILE_SIZE);
	localparam int QUEUE_DEPTH       = 2;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic CMD_DRAW  = 1'b0;
	localparam logic CMD_POWER = 1'b1;

	localparam logic KIND_WRITE   = 1'b0;
	localparam logic KIND_DISPLAY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_ROW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd6;

	typedef struct packed {
		logic        command;
		logic        power_save;
		logic [7:0]  start_column;
		logic [7:0]  tile_row;
		logic [7:0]  tile_in_run;
		logic [7:0]  run_length;
		logic [7:0]  pass_index;
		logic [63:0] tile_bits;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [7:0]  data;
		logic        display_on;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] first_offset;
		logic [15:0] row_stride;
		logic [15:0] line_stride;
		logic [3:0]  lines_per_row;
		logic [7:0]  tile_cols;
		logic [7:0]  tile_rows;
		logic [7:0]  column_offset;
	} cfg_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic               is_power;
		logic               power_save;
		logic [15:0]        base;
		logic [LINES_W-1:0] lines;
		logic [63:0]        rows;
	} job_t;

	// row r lands in bits 8r+7..8r; bit 7-j of row r is bit r of column byte j
	function automatic logic [63:0] transpose_tile(input logic [63:0] cols);
		logic [63:0] rows;
		rows = '0;
		for (int r = 0; r < TILE_SIZE; r++) begin
			for (int j = 0; j < TILE_SIZE; j++) begin
				rows[8*r + 7 - j] = cols[8*j + r];
			end
		end
		return rows;
	endfunction

endpackage

@@ rtl/tile_blit_transpose_writer.sv @@
// Top level of the tile blit transpose writer: config registers, front, queue, back.
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  req_t  (draw or power request)
//  res       out        res_valid/res_ready  res_t  (byte write or display update)
//  cfg       in         cfg_we               cfg_index, cfg_data
//
// A draw request is loaded, then gives one byte write per cycle unless res stalls, over
// 8 rows times the saturated lines_per_row; a power request gives one display update.
// The front end registers a request and classifies it in the next cycle; clipped
// requests are dropped there. A 2-deep job queue lets the front keep taking requests
// while the back end writes or res_ready is low. Reset clears handshake state,
// display enable and the config registers to their defaults.
module tile_blit_transpose_writer import tbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push;
	job_t push_data;
	logic full;
	logic pop;
	job_t head;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_offset  <= '0;
			cfg_q.row_stride    <= '0;
			cfg_q.line_stride   <= '0;
			cfg_q.lines_per_row <= 4'd1;
			cfg_q.tile_cols     <= 8'd80;
			cfg_q.tile_rows     <= 8'd60;
			cfg_q.column_offset <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_OFFSET:  cfg_q.first_offset  <= cfg_data;
				REG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data;
				REG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_data;
				REG_LINES_PER_ROW: cfg_q.lines_per_row <= cfg_data[3:0];
				REG_TILE_COLS:     cfg_q.tile_cols     <= cfg_data[7:0];
				REG_TILE_ROWS:     cfg_q.tile_rows     <= cfg_data[7:0];
				REG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ rtl/tbt_queue.sv @@
// Short queue of classified jobs between the front end and the back end.
module tbt_queue import tbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tbt_front.sv @@
// Front end: takes requests, clips them, works out base address and row bytes.
module tbt_front import tbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic push,
	output job_t push_data,
	input  logic full
);

	logic       valid_s1;
	req_t       req_s1;

	logic [7:0]         run_prod;
	logic [7:0]         base_col;
	logic [7:0]         col;
	logic [8:0]         last_col;
	logic               row_ok;
	logic               col_ok;
	logic [LINES_W-1:0] lines;
	logic [23:0]        row_prod;
	logic [15:0]        tile_off;
	logic               keep;
	logic               consumed;

	always_comb begin
		run_prod = 8'(req_s1.pass_index * req_s1.run_length);
		base_col = req_s1.start_column + run_prod;
		col      = base_col + req_s1.tile_in_run;
		last_col = {1'b0, base_col} + {1'b0, req_s1.tile_in_run};
		row_ok   = req_s1.tile_row < cfg.tile_rows;
		// a run stops at its first column past the limit; wrapping always crosses 255
		col_ok   = (base_col < cfg.tile_cols) && (last_col < {1'b0, cfg.tile_cols});
		if (int'(cfg.lines_per_row) > MAX_LINES_PER_ROW) begin
			lines = LINES_W'(MAX_LINES_PER_ROW);
		end else begin
			lines = LINES_W'(cfg.lines_per_row);
		end
		row_prod = req_s1.tile_row * cfg.row_stride;
		tile_off = {row_prod[15-ROW_SHIFT:0], {ROW_SHIFT{1'b0}}};
		keep = (req_s1.command == CMD_POWER) || (row_ok && col_ok && (lines != '0));

		push_data.is_power   = (req_s1.command == CMD_POWER);
		push_data.power_save = req_s1.power_save;
		push_data.base       = cfg.first_offset + tile_off + {8'd0, cfg.column_offset}
			+ {8'd0, col};
		push_data.lines      = lines;
		push_data.rows       = transpose_tile(req_s1.tile_bits);
	end

	assign push      = valid_s1 && keep;
	assign consumed  = valid_s1 && (!keep || !full);
	assign req_ready = !valid_s1 || consumed;

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

endmodule

@@ rtl/tbt_back.sv @@
// Back end: steps through rows and scanline repeats, drives the result register.
module tbt_back import tbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t head,
	input  logic empty,
	output logic pop,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic               busy_q;
	job_t               job_q;
	logic [ROW_W-1:0]   r_q;
	logic [LINES_W-1:0] s_q;
	logic [15:0]        row_addr_q;
	logic [15:0]        addr_q;
	logic               display_q;
	logic               out_valid_q;
	res_t               out_q;

	logic out_free;
	logic emit;
	logic row_end;
	logic job_end;
	res_t next_res;

	assign out_free = !out_valid_q || res_ready;
	assign emit     = busy_q && out_free;
	assign pop      = !busy_q && !empty;
	assign row_end  = (s_q == job_q.lines - LINES_W'(1));
	assign job_end  = job_q.is_power || (row_end && (r_q == ROW_W'(TILE_SIZE - 1)));

	always_comb begin
		if (job_q.is_power) begin
			next_res.kind       = KIND_DISPLAY;
			next_res.address    = '0;
			next_res.data       = '0;
			next_res.display_on = !job_q.power_save;
			next_res.last       = 1'b1;
		end else begin
			next_res.kind       = KIND_WRITE;
			next_res.address    = addr_q;
			next_res.data       = job_q.rows[{r_q, 3'b000} +: 8];
			next_res.display_on = display_q;
			next_res.last       = job_end;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q      <= head;
			r_q        <= '0;
			s_q        <= '0;
			row_addr_q <= head.base;
			addr_q     <= head.base;
		end else if (emit && !job_q.is_power) begin
			if (row_end) begin
				s_q        <= '0;
				r_q        <= r_q + 1'b1;
				row_addr_q <= row_addr_q + cfg.row_stride;
				addr_q     <= row_addr_q + cfg.row_stride;
			end else begin
				s_q    <= s_q + 1'b1;
				addr_q <= addr_q + cfg.line_stride;
			end
		end
		if (emit) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			display_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && job_end) begin
				busy_q <= 1'b0;
			end
			if (emit && job_q.is_power) begin
				display_q <= !job_q.power_save;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
